// ===== rtl/core/mtss_pkg.sv =====
// Shared types, constants and sine table math for the multi-tone sine synthesizer.
`default_nettype none

package mtss_pkg;

	localparam int DEF_TABLE_BITS = 10;
	localparam int DEF_PHASE_BITS = 32;

	localparam int COUNT_W     = 7;
	localparam int SAMPLE_W    = 17;
	localparam int GAIN_W      = 15;
	localparam int REG_W       = 32;
	localparam int ACTIVE_W    = 2;
	localparam int ADDR_W      = 3;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(64);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [7:0] TAYLOR_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72,
		8'd110, 8'd156, 8'd210};

	typedef enum logic [ADDR_W-1:0] {
		REG_TONE0_STEP   = 3'd0,
		REG_TONE1_STEP   = 3'd1,
		REG_TONE0_GAIN   = 3'd2,
		REG_TONE1_GAIN   = 3'd3,
		REG_TONE0_OFFSET = 3'd4,
		REG_TONE1_OFFSET = 3'd5,
		REG_ACTIVE_TONES = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0]    tone0_step;
		logic [REG_W-1:0]    tone1_step;
		logic [GAIN_W-1:0]   tone0_gain;
		logic [GAIN_W-1:0]   tone1_gain;
		logic [REG_W-1:0]    tone0_offset;
		logic [REG_W-1:0]    tone1_offset;
		logic [ACTIVE_W-1:0] active_tones;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] count;
	} req_t;

	// 32767*sin(m/2^qbits * pi/2), Q30 Taylor series up to x^15, rounded half up.
	function automatic logic [15:0] quarter_sine(input logic [15:0] m, input int qbits);
		logic [63:0]        x;
		logic [63:0]        t;
		logic signed [63:0] s;
		logic [63:0]        v;
		x = (64'(m) * HALF_PI_Q30) >> qbits;
		t = x;
		s = $signed(x);
		for (int n = 1; n <= 7; n++) begin
			t = (t * x) >> 30;
			t = (t * x) >> 30;
			t = t / 64'(TAYLOR_DIV[n]);
			if (n % 2 == 1) begin
				s = s - $signed(t);
			end else begin
				s = s + $signed(t);
			end
		end
		if (s < 0) begin
			s = '0;
		end
		v = (64'(s) * 64'd32767 + 64'd536870912) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mtss_rom.sv =====
// Sine lookup ROM with registered read, built at elaboration by quarter-wave symmetry.
`default_nettype none

module mtss_rom #(
	parameter int TABLE_BITS = mtss_pkg::DEF_TABLE_BITS
) (
	input  wire                    clk,
	input  wire                    en,
	input  wire [TABLE_BITS-1:0]   idx,
	output logic signed [15:0]     data_q
);
	import mtss_pkg::*;

	localparam int TABLE_LEN   = 1 << TABLE_BITS;
	localparam int QUARTER_BITS = TABLE_BITS - 2;
	localparam int QLEN        = 1 << QUARTER_BITS;

	typedef logic signed [15:0] rom_t [TABLE_LEN];

	function automatic rom_t build_rom();
		rom_t        r;
		logic [15:0] v;
		logic [15:0] rem;
		logic [1:0]  quad;
		for (int k = 0; k < TABLE_LEN; k++) begin
			quad = 2'(k >> QUARTER_BITS);
			rem  = 16'(k % QLEN);
			v = quad[0] ? quarter_sine(16'(QLEN) - rem, QUARTER_BITS)
				: quarter_sine(rem, QUARTER_BITS);
			r[k] = quad[1] ? -$signed(v) : $signed(v);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= SINE_ROM[idx];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mtss_front.sv =====
// Request front end: saturate the sample count, drop empty requests, queue the rest.
`default_nettype none

module mtss_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire [mtss_pkg::IN_TDATA_W-1:0] s_tdata,  // [6:0] sample_count
	output mtss_pkg::req_t              req,
	input  wire                         pop
);
	import mtss_pkg::*;

	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	logic [COUNT_W-1:0] queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [FILL_W-1:0]  fill_q;
	logic [COUNT_W-1:0] raw_count;
	logic [COUNT_W-1:0] sat_count;
	logic               push;
	logic               do_pop;

	assign raw_count = s_tdata[COUNT_W-1:0];
	assign sat_count = (raw_count > MAX_COUNT) ? MAX_COUNT : raw_count;
	assign s_tready  = (fill_q != FILL_W'(QUEUE_DEPTH));
	// an empty request produces nothing: take the transfer and drop it
	assign push      = s_tvalid && s_tready && (sat_count != '0);
	assign do_pop    = pop && (fill_q != '0);

	assign req.valid = (fill_q != '0);
	assign req.count = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= sat_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mtss_back.sv =====
// Sample engine: per-sample phase sequencer, table read, gain multiply, sum and output register.
`default_nettype none

module mtss_back #(
	parameter int TABLE_BITS = mtss_pkg::DEF_TABLE_BITS,
	parameter int PHASE_BITS = mtss_pkg::DEF_PHASE_BITS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  mtss_pkg::cfg_t                 cfg,
	input  mtss_pkg::req_t                 req,
	output logic                           pop,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [mtss_pkg::OUT_TDATA_W-1:0] m_tdata,  // [16:0] sample
	output logic                           m_tlast
);
	import mtss_pkg::*;

	localparam int UP_SHIFT   = (PHASE_BITS >= REG_W) ? PHASE_BITS - REG_W : 0;
	localparam int DOWN_SHIFT = (PHASE_BITS >= REG_W) ? 0 : REG_W - PHASE_BITS;
	localparam int WIDE_W     = REG_W + UP_SHIFT;

	function automatic logic [PHASE_BITS-1:0] scale_phase(input logic [REG_W-1:0] r);
		logic [WIDE_W-1:0] w;
		w = (WIDE_W'(r) << UP_SHIFT) >> DOWN_SHIFT;
		return w[PHASE_BITS-1:0];
	endfunction

	logic [PHASE_BITS-1:0] acc0_q;
	logic [PHASE_BITS-1:0] acc1_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic                  adv;
	logic                  issue;
	logic [PHASE_BITS-1:0] ph0;
	logic [PHASE_BITS-1:0] ph1;

	logic                  v_s1, v_s2, v_s3;
	logic                  last_s1, last_s2, last_s3;
	logic [TABLE_BITS-1:0] idx0_s1, idx1_s1;
	logic signed [15:0]    ent0_s2, ent1_s2;
	logic signed [31:0]    prod0_s3, prod1_s3;

	logic                  out_valid_q;
	logic                  out_last_q;
	logic [SAMPLE_W-1:0]   out_sample_q;

	logic signed [31:0]    rnd0, rnd1;
	logic signed [SAMPLE_W-1:0] term0, term1;
	logic [SAMPLE_W-1:0]   sum;

	// whole pipeline moves together, held while the output register is full
	assign adv   = !out_valid_q || m_tready;
	assign issue = adv && (cnt_q != '0);
	assign pop   = req.valid && ((cnt_q == '0) || (issue && cnt_q == COUNT_W'(1)));

	assign ph0 = acc0_q + scale_phase(cfg.tone0_offset);
	assign ph1 = acc1_q + scale_phase(cfg.tone1_offset);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc0_q <= '0;
			acc1_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (issue) begin
				acc0_q <= acc0_q + scale_phase(cfg.tone0_step);
				acc1_q <= acc1_q + scale_phase(cfg.tone1_step);
			end
			if (pop) begin
				cnt_q <= req.count;
			end else if (issue) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx0_s1  <= ph0[PHASE_BITS-1 -: TABLE_BITS];
			idx1_s1  <= ph1[PHASE_BITS-1 -: TABLE_BITS];
			last_s1  <= (cnt_q == COUNT_W'(1));
			last_s2  <= last_s1;
			prod0_s3 <= $signed({1'b0, cfg.tone0_gain}) * ent0_s2;
			prod1_s3 <= $signed({1'b0, cfg.tone1_gain}) * ent1_s2;
			last_s3  <= last_s2;
			out_sample_q <= sum;
			out_last_q   <= last_s3;
		end
	end

	mtss_rom #(.TABLE_BITS(TABLE_BITS)) u_rom0 (
		.clk    (clk),
		.en     (adv),
		.idx    (idx0_s1),
		.data_q (ent0_s2)
	);

	mtss_rom #(.TABLE_BITS(TABLE_BITS)) u_rom1 (
		.clk    (clk),
		.en     (adv),
		.idx    (idx1_s1),
		.data_q (ent1_s2)
	);

	// round half up, then floor by the arithmetic top slice
	assign rnd0  = prod0_s3 + 32'sd16384;
	assign rnd1  = prod1_s3 + 32'sd16384;
	assign term0 = $signed(rnd0[31:15]);
	assign term1 = $signed(rnd1[31:15]);
	assign sum   = ((cfg.active_tones != '0) ? term0 : '0)
		+ (cfg.active_tones[1] ? term1 : '0);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-SAMPLE_W){1'b0}}, out_sample_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_COUNT)
		else $error("remaining sample count above limit");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> req.valid)
		else $error("request taken from empty queue");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && cnt_q == COUNT_W'(1)) |=> (v_s1 && last_s1))
		else $error("final sample of request not marked last");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && v_s1) |=> (v_s1 && $stable(idx0_s1) && $stable(idx1_s1)))
		else $error("table index lost during output stall");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/multi_tone_sine_synth.sv =====
// Top level of the two-tone direct digital sine synthesizer.
`default_nettype none

// A request on the slave stream carries a sample count (1 to 64; larger counts
// saturate to 64, a count of zero is taken and produces nothing). For each
// sample the block outputs the sum of the active tones, each tone being
// gain * sine(phase accumulator + offset) with the sine read from a table of
// 2^TABLE_BITS signed 16-bit entries indexed by the top phase bits; the 32-bit
// phase accumulators then advance by their step registers, whether a tone is
// active or not. Results leave on the master stream, tlast marking the final
// sample of each request. After its transfer a request is written into the queue
// and then loaded into the sample counter before its first sample is issued. From
// then on the block delivers one sample per clock while the master side is ready,
// each sample passing through the phase add, table read, gain multiply, and
// round and sum registers in turn; the rate is set by the single
// phase-accumulator update each cycle. A two-entry request queue lets new
// requests be taken while earlier ones are still producing samples.
// Configuration registers (steps, gains, offsets, active tone count) are
// written through the plain write port and must only be changed while no
// request is in flight; an offset change takes effect on the next sample
// without touching the accumulators. The sine table is a constant ROM, so no
// clearing pass follows reset.
module multi_tone_sine_synth #(
	parameter int TABLE_BITS = mtss_pkg::DEF_TABLE_BITS,
	parameter int PHASE_BITS = mtss_pkg::DEF_PHASE_BITS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// request stream
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire [mtss_pkg::IN_TDATA_W-1:0]    s_tdata,   // [6:0] sample_count
	// sample stream
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [mtss_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [16:0] sample
	output logic                              m_tlast,
	// configuration write port
	input  wire                               cfg_we,
	input  wire [mtss_pkg::ADDR_W-1:0]        cfg_addr,
	input  wire [mtss_pkg::REG_W-1:0]         cfg_wdata
);
	import mtss_pkg::*;

	cfg_t cfg_q;
	req_t req;
	logic pop;

	// Register file: hold each value until rewritten; drop writes to unused
	// indexes and any data bits above a register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tone0_step   <= '0;
			cfg_q.tone1_step   <= '0;
			cfg_q.tone0_gain   <= '0;
			cfg_q.tone1_gain   <= '0;
			cfg_q.tone0_offset <= '0;
			cfg_q.tone1_offset <= '0;
			cfg_q.active_tones <= ACTIVE_W'(2);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_TONE0_STEP:   cfg_q.tone0_step   <= cfg_wdata;
				REG_TONE1_STEP:   cfg_q.tone1_step   <= cfg_wdata;
				REG_TONE0_GAIN:   cfg_q.tone0_gain   <= cfg_wdata[GAIN_W-1:0];
				REG_TONE1_GAIN:   cfg_q.tone1_gain   <= cfg_wdata[GAIN_W-1:0];
				REG_TONE0_OFFSET: cfg_q.tone0_offset <= cfg_wdata;
				REG_TONE1_OFFSET: cfg_q.tone1_offset <= cfg_wdata;
				REG_ACTIVE_TONES: cfg_q.active_tones <= cfg_wdata[ACTIVE_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// Front end: take request transfers and queue them.
	mtss_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.req      (req),
		.pop      (pop)
	);

	// Back end: walk each request one sample per cycle into the output register, held while that register is full.
	mtss_back #(
		.TABLE_BITS (TABLE_BITS),
		.PHASE_BITS (PHASE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req      (req),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== tb/tb_multi_tone_sine_synth.sv =====
// Self-checking testbench for the two-tone direct digital sine synthesizer.
`timescale 1ns / 100ps

module tb_multi_tone_sine_synth;
	import mtss_pkg::*;

	// Timing and run shape
	localparam int ROM_BITS      = 10;
	localparam int ROM_LEN       = 1 << ROM_BITS;
	localparam int QTR_BITS      = ROM_BITS - 2;
	localparam int SAMPLES_MAX   = 64;
	localparam int ITEMS_TOTAL   = 450;
	localparam int QUIET_TAIL    = 60;    // final requests run with no idling
	localparam int SETTLE_CYCLES = 16;    // pipeline is four deep, leave margin
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int STALL_LIMIT   = 2000;  // cycles without any transfer

	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

	// Address past the last register; writes to it must be dropped
	localparam logic [ADDR_W-1:0] REG_SPARE = 3'd7;

	typedef struct {
		logic signed [SAMPLE_W-1:0] value;
		logic                       last;
	} synth_sample_t;

	// Scoreboard: mirrors the tone registers and phase accumulators, expands each
	// accepted request into the samples it must produce, and checks them in order.
	class synth_scoreboard;
		logic [REG_W-1:0]    step [2];
		logic [GAIN_W-1:0]   gain [2];
		logic [REG_W-1:0]    offset [2];
		logic [ACTIVE_W-1:0] active;
		logic [REG_W-1:0]    phase [2];
		logic signed [15:0]  sine_rom [ROM_LEN];
		synth_sample_t       pending_samples [$];
		int errors, requests, zero_requests, clipped_requests, samples_checked, reg_writes;

		function new();
			int unsigned quad;
			int unsigned pos;
			int          mag;
			for (int k = 0; k < ROM_LEN; k++) begin
				quad = k >> QTR_BITS;
				pos  = k & ((1 << QTR_BITS) - 1);
				mag  = quad[0] ? quarter_wave((1 << QTR_BITS) - pos) : quarter_wave(pos);
				sine_rom[k] = quad[1] ? 16'(-mag) : 16'(mag);
			end
			step   = '{default: '0};
			gain   = '{default: '0};
			offset = '{default: '0};
			phase  = '{default: '0};
			active = ACTIVE_W'(2);
		endfunction

		// 32767*sin(m/2^QTR_BITS * pi/2) by a Q30 series up to the x^15 term
		function int quarter_wave(int unsigned m);
			longint unsigned x;
			longint unsigned t;
			longint          s;
			longint          v;
			x = (longint'(m) * QUARTER_TURN_Q30) >> QTR_BITS;
			t = x;
			s = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				t = (t * x) >> 30;
				t = (t * x) >> 30;
				t = t / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					s = s - longint'(t);
				end else begin
					s = s + longint'(t);
				end
			end
			if (s < 0) begin
				s = 0;
			end
			v = (s * 32767 + (longint'(1) << 29)) >>> 30;
			if (v > 32767) begin
				v = 32767;
			end
			return int'(v);
		endfunction

		function void set_reg(logic [ADDR_W-1:0] idx, logic [REG_W-1:0] data);
			reg_writes++;
			case (idx)
				REG_TONE0_STEP:   step[0]   = data;
				REG_TONE1_STEP:   step[1]   = data;
				REG_TONE0_GAIN:   gain[0]   = data[GAIN_W-1:0];
				REG_TONE1_GAIN:   gain[1]   = data[GAIN_W-1:0];
				REG_TONE0_OFFSET: offset[0] = data;
				REG_TONE1_OFFSET: offset[1] = data;
				REG_ACTIVE_TONES: active    = data[ACTIVE_W-1:0];
				default: ;
			endcase
		endfunction

		// gain * sine(acc + offset), rounded half up to an integer
		function int tone_term(int tone);
			logic [REG_W-1:0] ph;
			longint           prod;
			ph   = phase[tone] + offset[tone];
			prod = longint'(gain[tone]) * longint'(sine_rom[ph[REG_W-1 -: ROM_BITS]]);
			return int'((prod + 16384) >>> 15);
		endfunction

		function void note_request(logic [COUNT_W-1:0] cnt);
			int            n;
			int            tones;
			int            sum;
			synth_sample_t s;
			n     = (cnt > SAMPLES_MAX) ? SAMPLES_MAX : int'(cnt);
			tones = (active > 2) ? 2 : int'(active);
			requests++;
			if (cnt == 0) begin
				zero_requests++;
			end
			if (cnt > SAMPLES_MAX) begin
				clipped_requests++;
			end
			for (int i = 0; i < n; i++) begin
				sum = 0;
				for (int t = 0; t < tones; t++) begin
					sum += tone_term(t);
				end
				s.value = sum[SAMPLE_W-1:0];
				s.last  = (i == n - 1);
				pending_samples.push_back(s);
				// both accumulators run whether or not their tone is summed
				phase[0] = phase[0] + step[0];
				phase[1] = phase[1] + step[1];
			end
		endfunction

		function void check_sample(logic signed [SAMPLE_W-1:0] value, logic last);
			synth_sample_t e;
			if (pending_samples.size() == 0) begin
				$error("sample: none expected, got %0d (last %0b)", value, last);
				errors++;
				return;
			end
			e = pending_samples.pop_front();
			samples_checked++;
			if (value !== e.value) begin
				$error("sample: expected %0d, got %0d", e.value, value);
				errors++;
			end
			if (last !== e.last) begin
				$error("last: expected %0b, got %0b", e.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_samples.size();
		endfunction
	endclass

	// DUT interface; every input starts at a known value
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;  // [6:0] sample_count
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // [16:0] sample
	logic                   m_tlast;
	logic                   cfg_we    = 1'b0;
	logic [ADDR_W-1:0]      cfg_addr  = '0;
	logic [REG_W-1:0]       cfg_wdata = '0;

	multi_tone_sine_synth dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	synth_scoreboard  sb;
	logic [REG_W-1:0] reg_shadow [8];   // values the next config pass writes
	int  gap_pct    = 0;                // sender idle chance per request
	int  stall_pct  = 0;                // receiver stall chance per burst
	bit  quiet      = 1'b0;             // tail of the run: no idling at all
	bit  hold_out   = 1'b0;             // request for one long receiver hold-off
	int  settings   = 0;
	int  in_stalls  = 0;

	// Receiver: alternate ready bursts with stall bursts; honor a long hold
	// request by counting it down here, independent of the sender.
	initial begin
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_out) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_out = 1'b0;
			end else if (!quiet && $urandom_range(99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	// Output monitor: every transfer on the sample stream is checked in order
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_sample(m_tdata[SAMPLE_W-1:0], m_tlast);
		end
		if (arst_n && s_tvalid && !s_tready) begin
			in_stalls++;
		end
	end

	// Watchdog: give up when no transfer of any kind happens for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no transfer in %0d cycles, %0d samples outstanding",
					STALL_LIMIT, sb.pending());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Offer one request, with an optional idle gap first; returns on the falling
	// edge after the transfer with tvalid still high.
	task automatic send_request(input logic [COUNT_W-1:0] cnt);
		if (!quiet && $urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(cnt);
		do @(posedge clk); while (!s_tready);
		sb.note_request(cnt);
		@(negedge clk);
	endtask

	// Drop tvalid and wait until every sample is out; zero-count requests
	// produce nothing, so let the pipeline settle before touching registers.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Write every register from the shadow, optionally poke the spare address
	task automatic apply_config(input bit touch_spare);
		reg_idx_t r;
		drain();
		r = r.first();
		do begin
			cfg_we    <= 1'b1;
			cfg_addr  <= r;
			cfg_wdata <= reg_shadow[r];
			@(posedge clk);
			sb.set_reg(r, reg_shadow[r]);
			@(negedge clk);
			r = r.next();
		end while (r != r.first());
		if (touch_spare) begin
			cfg_addr  <= REG_SPARE;
			cfg_wdata <= $urandom;
			@(posedge clk);
			sb.set_reg(REG_SPARE, cfg_wdata);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic logic [REG_W-1:0] pick_phase();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return REG_W'($urandom_range(32'h00ff_ffff));  // slow tone
			3: return 32'h8000_0000;
			4: return 32'h0100_0000 << $urandom_range(7);
			default: return $urandom;
		endcase
	endfunction

	// Gains carry random junk above bit 14, which the block must drop
	function automatic logic [REG_W-1:0] pick_gain();
		logic [REG_W-1:0] g;
		g = $urandom;
		case ($urandom_range(3))
			0: g[GAIN_W-1:0] = '0;
			1: g[GAIN_W-1:0] = '1;
			default: ;
		endcase
		return g;
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 6) return '0;
		if (r < 12) return COUNT_W'($urandom_range(65, 127));
		if (r < 20) return COUNT_W'(SAMPLES_MAX);
		if (r < 35) return COUNT_W'($urandom_range(1, 4));
		return COUNT_W'($urandom_range(1, SAMPLES_MAX));
	endfunction

	initial begin
		int batch;
		int phase_no;
		int left;
		sb = new();
		reg_shadow = '{default: '0};
		reg_shadow[REG_ACTIVE_TONES] = REG_W'(2);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset registers give silence
		gap_pct   = 25;
		stall_pct = 25;
		send_request(COUNT_W'(5));

		// Full-scale gains (one with junk high bits), two slow tones; count edge
		// cases: the longest request, zero, all-ones saturating, single, just over
		reg_shadow[REG_TONE0_STEP] = 32'h0100_0000;
		reg_shadow[REG_TONE1_STEP] = 32'h0040_0000;
		reg_shadow[REG_TONE0_GAIN] = 32'hffff_ffff;
		reg_shadow[REG_TONE1_GAIN] = 32'h0000_7fff;
		apply_config(1'b1);
		send_request(COUNT_W'(64));
		send_request(COUNT_W'(0));
		send_request(COUNT_W'(127));
		send_request(COUNT_W'(1));
		send_request(COUNT_W'(65));

		// One tone, no tones (accumulators keep running), active count of three
		reg_shadow[REG_ACTIVE_TONES] = REG_W'(1);
		apply_config(1'b0);
		send_request(COUNT_W'(16));
		reg_shadow[REG_ACTIVE_TONES] = REG_W'(0);
		apply_config(1'b0);
		send_request(COUNT_W'(8));
		reg_shadow[REG_ACTIVE_TONES] = REG_W'(3);
		apply_config(1'b0);
		send_request(COUNT_W'(16));

		// Offsets changed between requests shift the phase at once
		reg_shadow[REG_ACTIVE_TONES] = REG_W'(2);
		reg_shadow[REG_TONE0_OFFSET] = 32'h8000_0000;
		reg_shadow[REG_TONE1_OFFSET] = 32'hffff_ffff;
		apply_config(1'b1);
		send_request(COUNT_W'(10));

		// Extreme steps and gains
		reg_shadow[REG_TONE0_STEP] = 32'hffff_ffff;
		reg_shadow[REG_TONE1_STEP] = '0;
		reg_shadow[REG_TONE0_GAIN] = '0;
		reg_shadow[REG_TONE1_GAIN] = 32'h0000_7fff;
		apply_config(1'b0);
		send_request(COUNT_W'(20));
		send_request(COUNT_W'(33));

		// Half- and quarter-cycle steps land exactly on table quadrant points
		reg_shadow[REG_TONE0_STEP]   = 32'h8000_0000;
		reg_shadow[REG_TONE1_STEP]   = 32'h4000_0000;
		reg_shadow[REG_TONE0_GAIN]   = REG_W'(1);
		reg_shadow[REG_TONE1_GAIN]   = REG_W'(32766);
		reg_shadow[REG_TONE0_OFFSET] = 32'h4000_0000;
		reg_shadow[REG_TONE1_OFFSET] = '0;
		apply_config(1'b0);
		send_request(COUNT_W'(3));
		send_request(COUNT_W'(2));

		// Random phases: new register settings, then a batch of random requests
		phase_no = 0;
		while (sb.requests < ITEMS_TOTAL) begin
			left = ITEMS_TOTAL - sb.requests;
			quiet = (left <= QUIET_TAIL);
			case ($urandom_range(2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 50;
			endcase
			case ($urandom_range(2))
				0: stall_pct = 0;
				1: stall_pct = 15;
				default: stall_pct = 50;
			endcase
			reg_shadow[REG_TONE0_STEP]   = pick_phase();
			reg_shadow[REG_TONE1_STEP]   = pick_phase();
			reg_shadow[REG_TONE0_GAIN]   = pick_gain();
			reg_shadow[REG_TONE1_GAIN]   = pick_gain();
			reg_shadow[REG_TONE0_OFFSET] = pick_phase();
			reg_shadow[REG_TONE1_OFFSET] = pick_phase();
			reg_shadow[REG_ACTIVE_TONES] = REG_W'($urandom_range(3));
			apply_config($urandom_range(2) == 0);

			batch = quiet ? left : $urandom_range(25, 50);
			if (batch > left) begin
				batch = left;
			end
			for (int i = 0; i < batch; i++) begin
				if (phase_no == 1 && i == batch / 2) begin
					// hold the sample stream off while requests keep coming,
					// so the request queue fills and backs up the input
					hold_out = 1'b1;
				end
				if (phase_no == 2 && i == batch / 2) begin
					// pause the requests until every sample has come out
					drain();
				end
				send_request(pick_count());
			end
			phase_no++;
		end

		drain();
		$display("Covered %0d requests (%0d zero-count, %0d over the limit), %0d samples checked",
			sb.requests, sb.zero_requests, sb.clipped_requests, sb.samples_checked);
		$display("Used %0d register settings, %0d writes; input held back for %0d cycles",
			settings, sb.reg_writes, in_stalls);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
